// ===== hw/rtl/brf_pkg.sv =====
// ----------------------------------------------------------------------------
// brf_pkg
// Shared widths, operation codes and the command and result words of the
// byte ring fifo.
// ----------------------------------------------------------------------------
package brf_pkg;

    localparam int W_BYTE   = 8;
    localparam int W_LVL    = 11;   // levels, run count, capacity
    localparam int W_CNT    = 7;    // pop count
    localparam int OQ_DEPTH = 4;    // result queue entries
    localparam int OQ_AW    = 2;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // classified command between front and back
    typedef struct packed {
        logic              op;
        logic [W_BYTE-1:0] data;
        logic              last;
        logic [W_CNT-1:0]  want;   // pop count already clamped
    } t_cmd;

    // one result word
    typedef struct packed {
        logic              accepted;
        logic [W_LVL-1:0]  run;
        logic [W_BYTE-1:0] data;
        logic              valid;
        logic              last;
        logic [W_LVL-1:0]  used;
        logic [W_LVL-1:0]  free;
    } t_res;

endpackage

// ===== hw/rtl/brf_ram.sv =====
// ----------------------------------------------------------------------------
// brf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module brf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/brf_front.sv =====
// ----------------------------------------------------------------------------
// brf_front
// Accepts input words, classifies them and holds them in a two-entry
// command queue for the back end.
// ----------------------------------------------------------------------------
module brf_front
    import brf_pkg::*;
#(
    parameter int MAX_POP = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    output logic              o_full,
    input  logic              i_operation,
    input  logic [W_BYTE-1:0] i_push_byte,
    input  logic              i_push_last,
    input  logic [W_CNT-1:0]  i_pop_count,
    output logic              o_cmd_vld,
    output t_cmd              o_cmd,
    input  logic              i_cmd_take
);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    logic       wr_en;
    t_cmd       cmd_in;

    assign o_full    = (r_cnt == 2'd2);
    assign wr_en     = i_push && !o_full;
    assign o_cmd_vld = (r_cnt != 2'd0);
    assign o_cmd     = r_q[r_rp];

    always_comb begin
        cmd_in      = '0;
        cmd_in.op   = (i_operation == OP_POP) ? OP_POP : OP_PUSH;
        cmd_in.data = i_push_byte;
        cmd_in.last = i_push_last;
        // pop counts above the limit act as the limit
        cmd_in.want = (32'(i_pop_count) > MAX_POP) ? W_CNT'(MAX_POP) : i_pop_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (i_cmd_take) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(wr_en) - 2'(i_cmd_take);
        end
        if (wr_en) begin
            r_q[r_wp] <= cmd_in;
        end
    end

endmodule

// ===== hw/rtl/brf_outq.sv =====
// ----------------------------------------------------------------------------
// brf_outq
// Small result queue between the back end and the result ports.
// ----------------------------------------------------------------------------
module brf_outq
    import brf_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_wr,
    input  t_res             i_res,
    output logic [OQ_AW:0]   o_cnt,
    output logic             o_empty,
    input  logic             i_pop,
    output t_res             o_res
);

    t_res             r_q [OQ_DEPTH];
    logic [OQ_AW-1:0] r_wp;
    logic [OQ_AW-1:0] r_rp;
    logic [OQ_AW:0]   r_cnt;
    logic             rd_en;

    assign o_cnt   = r_cnt;
    assign o_empty = (r_cnt == '0);
    assign rd_en   = i_pop && !o_empty;
    assign o_res   = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (rd_en) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (OQ_AW+1)'(i_wr) - (OQ_AW+1)'(rd_en);
        end
        if (i_wr) begin
            r_q[r_wp] <= i_res;
        end
    end

endmodule

// ===== hw/rtl/brf_back.sv =====
// ----------------------------------------------------------------------------
// brf_back
// Executes push and pop commands against the ring store: owns the write and
// read positions, the run count and the capacity register.
// ----------------------------------------------------------------------------
module brf_back
    import brf_pkg::*;
#(
    parameter int STORE_DEPTH = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [W_LVL-1:0] i_cfg_data,
    input  logic             i_cmd_vld,
    input  t_cmd             i_cmd,
    output logic             o_cmd_take,
    input  logic [OQ_AW:0]   i_oq_cnt,
    output logic             o_res_vld,
    output t_res             o_res
);

    localparam int CAP_MAX = (STORE_DEPTH < 2047) ? STORE_DEPTH : 2047;
    localparam int PW      = $clog2(2 * CAP_MAX);
    localparam int EW      = ((PW > W_LVL) ? PW : W_LVL) + 1;
    localparam int AW      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int RW      = $clog2(STORE_DEPTH + 1);
    localparam logic [W_LVL-1:0] CAP_RST = W_LVL'((CAP_MAX < 1024) ? CAP_MAX : 1024);

    typedef enum logic {S_IDLE, S_POP} t_state;

    t_state           r_state, n_state;
    logic [PW-1:0]    r_wr, n_wr;
    logic [PW-1:0]    r_rd, n_rd;
    logic [RW-1:0]    r_run, n_run;
    logic [W_LVL-1:0] r_cap;
    logic [W_CNT-1:0] r_left, n_left;
    logic             r_s1_vld, n_s1_vld;
    logic             r_s1_ram, n_s1_ram;
    t_res             r_s1, n_s1;

    logic [EW-1:0]    wr_e, rd_e, cap_e, cap2_e, used_e, wr_slot_e, rd_slot_e;
    logic [EW-1:0]    wr_inc, rd_inc;
    logic [PW-1:0]    wr_next, rd_next;
    logic [AW-1:0]    wr_slot, rd_slot;
    logic [W_LVL-1:0] used, used_p1, used_m1, cfg_cap;
    logic [RW-1:0]    run_inc;
    logic             room, ram_we, ram_re, is_last;
    logic [W_BYTE-1:0] ram_q;

    // level and slot arithmetic on the extra-lap positions
    always_comb begin
        wr_e      = EW'(r_wr);
        rd_e      = EW'(r_rd);
        cap_e     = EW'(r_cap);
        cap2_e    = cap_e << 1;
        used_e    = (wr_e >= rd_e) ? (wr_e - rd_e) : (wr_e + cap2_e - rd_e);
        used      = W_LVL'(used_e);
        used_p1   = used + 1'b1;
        used_m1   = used - 1'b1;
        wr_slot_e = (wr_e < cap_e) ? wr_e : (wr_e - cap_e);
        rd_slot_e = (rd_e < cap_e) ? rd_e : (rd_e - cap_e);
        wr_slot   = AW'(wr_slot_e);
        rd_slot   = AW'(rd_slot_e);
        wr_inc    = wr_e + 1'b1;
        rd_inc    = rd_e + 1'b1;
        wr_next   = (wr_inc == cap2_e) ? '0 : PW'(wr_inc);
        rd_next   = (rd_inc == cap2_e) ? '0 : PW'(rd_inc);
        run_inc   = (32'(r_run) < STORE_DEPTH) ? (r_run + 1'b1) : r_run;
        is_last   = (r_left == W_CNT'(1)) || (used == W_LVL'(1));
        room      = (({1'b0, i_oq_cnt}) + (OQ_AW+2)'(r_s1_vld)) < (OQ_AW+2)'(OQ_DEPTH);
        if (i_cfg_data == '0) begin
            cfg_cap = W_LVL'(1);
        end else if (32'(i_cfg_data) > CAP_MAX) begin
            cfg_cap = W_LVL'(CAP_MAX);
        end else begin
            cfg_cap = i_cfg_data;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_wr       = r_wr;
        n_rd       = r_rd;
        n_run      = r_run;
        n_left     = r_left;
        n_s1_vld   = 1'b0;
        n_s1_ram   = 1'b0;
        n_s1       = r_s1;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        o_cmd_take = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_cmd_vld && room) begin
                    o_cmd_take = 1'b1;
                    n_s1       = '0;
                    n_s1.last  = 1'b1;
                    if (i_cmd.op == OP_PUSH) begin
                        n_s1_vld = 1'b1;
                        if (used < r_cap) begin
                            ram_we          = 1'b1;
                            n_wr            = wr_next;
                            n_s1.accepted   = 1'b1;
                            n_s1.run        = W_LVL'(run_inc);
                            n_s1.used       = used_p1;
                            n_s1.free       = r_cap - used_p1;
                            n_run           = i_cmd.last ? '0 : run_inc;
                        end else begin
                            n_s1.run  = W_LVL'(r_run);
                            n_s1.used = used;
                            n_s1.free = r_cap - used;
                            n_run     = i_cmd.last ? '0 : r_run;
                        end
                    end else if ((i_cmd.want == '0) || (used == '0)) begin
                        // nothing to return: one invalid word
                        n_s1_vld  = 1'b1;
                        n_s1.used = used;
                        n_s1.free = r_cap - used;
                    end else begin
                        n_state = S_POP;
                        n_left  = i_cmd.want;
                    end
                end
            end
            S_POP: begin
                if (room) begin
                    ram_re     = 1'b1;
                    n_rd       = rd_next;
                    n_s1_vld   = 1'b1;
                    n_s1_ram   = 1'b1;
                    n_s1       = '0;
                    n_s1.valid = 1'b1;
                    n_s1.last  = is_last;
                    n_s1.used  = used_m1;
                    n_s1.free  = r_cap - used_m1;
                    n_left     = r_left - 1'b1;
                    if (is_last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wr     <= '0;
            r_rd     <= '0;
            r_run    <= '0;
            r_cap    <= CAP_RST;
            r_s1_vld <= 1'b0;
        end else if (i_cfg_we) begin
            // new capacity empties the ring
            r_state  <= S_IDLE;
            r_wr     <= '0;
            r_rd     <= '0;
            r_run    <= '0;
            r_cap    <= cfg_cap;
            r_s1_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_wr     <= n_wr;
            r_rd     <= n_rd;
            r_run    <= n_run;
            r_s1_vld <= n_s1_vld;
        end
        r_left   <= n_left;
        r_s1     <= n_s1;
        r_s1_ram <= n_s1_ram;
    end

    brf_ram #(
        .WIDTH (W_BYTE),
        .DEPTH (STORE_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (wr_slot),
        .i_wdata (i_cmd.data),
        .i_re    (ram_re),
        .i_raddr (rd_slot),
        .o_rdata (ram_q)
    );

    // read data joins its word in the cycle after the address is given
    always_comb begin
        o_res_vld = r_s1_vld;
        o_res     = r_s1;
        o_res.data = r_s1_ram ? ram_q : '0;
    end

endmodule

// ===== hw/rtl/byte_ring_fifo.sv =====
// ----------------------------------------------------------------------------
// byte_ring_fifo
// Byte fifo on a ring store with extra-lap positions, fronted by a command
// queue and backed by a result queue.
// ----------------------------------------------------------------------------
// path: a push word goes through the command queue, the execute register and
// the result queue to the result ports; a pop's bytes take the same path
// rate: one push per cycle while the result queue has room; a pop is taken
// first, then one byte per cycle with room, set by the single ram read port
// reset: synchronous active low; pointers, run count and queues clear at once,
// capacity returns to 1024 (or the store depth), the byte store is not cleared
// ----------------------------------------------------------------------------
module byte_ring_fifo
    import brf_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_POP     = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // input word side
    input  logic              push,
    output logic              full,
    input  logic              i_operation,
    input  logic [W_BYTE-1:0] i_push_byte,
    input  logic              i_push_last,
    input  logic [W_CNT-1:0]  i_pop_count,
    // result word side
    output logic              empty,
    input  logic              pop,
    output logic              o_accepted,
    output logic [W_LVL-1:0]  o_accepted_in_run,
    output logic [W_BYTE-1:0] o_out_byte,
    output logic              o_out_valid,
    output logic              o_last,
    output logic [W_LVL-1:0]  o_used_bytes,
    output logic [W_LVL-1:0]  o_free_bytes,
    // capacity register write
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [W_LVL-1:0]  i_cfg_data
);

    logic           cmd_vld;
    t_cmd           cmd;
    logic           cmd_take;
    logic [OQ_AW:0] oq_cnt;
    logic           res_vld;
    t_res           res_in;
    t_res           res_out;
    logic           cfg_we;

    // user keeps capacity writes to idle times; unchecked, so always taken
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;

    // front: take and classify input words
    brf_front #(
        .MAX_POP (MAX_POP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_full      (full),
        .i_operation (i_operation),
        .i_push_byte (i_push_byte),
        .i_push_last (i_push_last),
        .i_pop_count (i_pop_count),
        .o_cmd_vld   (cmd_vld),
        .o_cmd       (cmd),
        .i_cmd_take  (cmd_take)
    );

    // back: ring pointers, store and sequencing of pop bytes
    brf_back #(
        .STORE_DEPTH (STORE_DEPTH)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cmd_vld  (cmd_vld),
        .i_cmd      (cmd),
        .o_cmd_take (cmd_take),
        .i_oq_cnt   (oq_cnt),
        .o_res_vld  (res_vld),
        .o_res      (res_in)
    );

    // result queue decouples the back end from the consumer
    brf_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (res_vld),
        .i_res   (res_in),
        .o_cnt   (oq_cnt),
        .o_empty (empty),
        .i_pop   (pop),
        .o_res   (res_out)
    );

    assign o_accepted        = res_out.accepted;
    assign o_accepted_in_run = res_out.run;
    assign o_out_byte        = res_out.data;
    assign o_out_valid       = res_out.valid;
    assign o_last            = res_out.last;
    assign o_used_bytes      = res_out.used;
    assign o_free_bytes      = res_out.free;

    // the back end never writes a full result queue
    a_oq_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        res_vld |-> (oq_cnt != (OQ_AW+1)'(OQ_DEPTH)))
        else $error("result queue overflow");

    // an accepted push result is always a single last word without data
    a_push_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_accepted) |-> (o_last && !o_out_valid))
        else $error("malformed push result");

    // after reset both sides are open and nothing is pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> (!full && empty))
        else $error("queues not cleared by reset");

endmodule

// ===== test/byte_ring_fifo_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// byte_ring_fifo_checker
// Watches the input, result and capacity channels of the byte ring fifo,
// keeps its own copy of the ring and compares every result word in order.
// ----------------------------------------------------------------------------
module byte_ring_fifo_checker
    import brf_pkg::*;
#(
    parameter int STORE_DEPTH = 1024,
    parameter int MAX_POP     = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic              i_full,
    input  logic              i_operation,
    input  logic [W_BYTE-1:0] i_push_byte,
    input  logic              i_push_last,
    input  logic [W_CNT-1:0]  i_pop_count,
    input  logic              i_empty,
    input  logic              i_pop,
    input  logic              i_accepted,
    input  logic [W_LVL-1:0]  i_accepted_in_run,
    input  logic [W_BYTE-1:0] i_out_byte,
    input  logic              i_out_valid,
    input  logic              i_last,
    input  logic [W_LVL-1:0]  i_used_bytes,
    input  logic [W_LVL-1:0]  i_free_bytes,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [W_LVL-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending,
    output int                o_checked
);

    logic [W_BYTE-1:0] ring_mem [STORE_DEPTH];
    logic [W_LVL-1:0]  cap_reg;
    int                wr_pos;
    int                rd_pos;
    int                run_count;
    int                errors;
    int                pending;
    int                checked;
    t_res              expected_words [$];

    assign o_errors  = errors;
    assign o_pending = pending;
    assign o_checked = checked;

    // out-of-range capacity clamps to 1..STORE_DEPTH
    function automatic int cap_now();
        int c;
        c = int'(cap_reg);
        if (c == 0) c = 1;
        if (c > STORE_DEPTH) c = STORE_DEPTH;
        return c;
    endfunction

    function automatic int level(input int cap);
        if (wr_pos >= rd_pos) return wr_pos - rd_pos;
        return wr_pos + 2 * cap - rd_pos;
    endfunction

    function automatic int next_pos(input int pos, input int cap);
        return (pos + 1 >= 2 * cap) ? pos + 1 - 2 * cap : pos + 1;
    endfunction

    function automatic int slot_of(input int pos, input int cap);
        return (pos < cap) ? pos : pos - cap;
    endfunction

    function automatic t_res make_word(input logic acc, input int run,
                                       input logic [W_BYTE-1:0] data,
                                       input logic valid, input logic lst,
                                       input int cap);
        t_res w;
        int   lvl;
        lvl        = level(cap);
        w.accepted = acc;
        w.run      = W_LVL'(run);
        w.data     = data;
        w.valid    = valid;
        w.last     = lst;
        w.used     = W_LVL'(lvl);
        w.free     = W_LVL'(cap - lvl);
        return w;
    endfunction

    task automatic predict_ring_step(input logic op, input logic [W_BYTE-1:0] data,
                                     input logic lst, input logic [W_CNT-1:0] cnt);
        int                cap;
        int                want;
        int                n;
        int                k;
        logic              acc;
        logic [W_BYTE-1:0] rd_byte;
        cap = cap_now();
        if (op == OP_PUSH) begin
            acc = 1'b0;
            if (level(cap) < cap) begin
                ring_mem[slot_of(wr_pos, cap)] = data;
                wr_pos = next_pos(wr_pos, cap);
                acc    = 1'b1;
                if (run_count < STORE_DEPTH) run_count++;
            end
            expected_words.push_back(make_word(acc, run_count, '0, 1'b0, 1'b1, cap));
            if (lst) run_count = 0;
        end else begin
            want = (int'(cnt) > MAX_POP) ? MAX_POP : int'(cnt);
            n    = (want < level(cap)) ? want : level(cap);
            if (n == 0)
                expected_words.push_back(make_word(1'b0, 0, '0, 1'b0, 1'b1, cap));
            for (k = 0; k < n; k++) begin
                rd_byte = ring_mem[slot_of(rd_pos, cap)];
                rd_pos  = next_pos(rd_pos, cap);
                expected_words.push_back(make_word(1'b0, 0, rd_byte, 1'b1,
                                                   k == n - 1, cap));
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_res got;
        t_res want_word;
        if (!i_rst_n) begin
            cap_reg   = W_LVL'(1024);
            wr_pos    = 0;
            rd_pos    = 0;
            run_count = 0;
            errors    = 0;
            checked   = 0;
            expected_words.delete();
        end else begin
            // results leave before new predictions are queued
            if (i_pop && !i_empty) begin
                got.accepted = i_accepted;
                got.run      = i_accepted_in_run;
                got.data     = i_out_byte;
                got.valid    = i_out_valid;
                got.last     = i_last;
                got.used     = i_used_bytes;
                got.free     = i_free_bytes;
                checked++;
                if (expected_words.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result word %0d: byte=%02h valid=%0d last=%0d",
                                 checked, got.data, got.valid, got.last);
                end else begin
                    want_word = expected_words.pop_front();
                    if (got !== want_word) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("result word %0d mismatch", checked);
                            $display("  expected acc=%0d run=%0d byte=%02h valid=%0d last=%0d used=%0d free=%0d",
                                     want_word.accepted, want_word.run, want_word.data,
                                     want_word.valid, want_word.last, want_word.used,
                                     want_word.free);
                            $display("  actual   acc=%0d run=%0d byte=%02h valid=%0d last=%0d used=%0d free=%0d",
                                     got.accepted, got.run, got.data, got.valid,
                                     got.last, got.used, got.free);
                        end
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                cap_reg   = i_cfg_data;
                wr_pos    = 0;
                rd_pos    = 0;
                run_count = 0;
            end
            if (i_push && !i_full)
                predict_ring_step(i_operation, i_push_byte, i_push_last, i_pop_count);
        end
        pending = expected_words.size();
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the byte ring fifo with directed and random push and pop words,
// capacity changes and a long receiver stall, and reports the verdict from
// the checker that runs beside it.
// ----------------------------------------------------------------------------
module tb;
    import brf_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;   // cycles with no handshake at all
    localparam int HOLD_CYCLES    = 200;    // long receiver stall
    localparam int END_SETTLE     = 20;     // settle time after the last drain
    localparam int RANDOM_WORDS   = 27;     // per random phase

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic              i_operation;
    logic [W_BYTE-1:0] i_push_byte;
    logic              i_push_last;
    logic [W_CNT-1:0]  i_pop_count;
    logic              empty;
    logic              pop;
    logic              o_accepted;
    logic [W_LVL-1:0]  o_accepted_in_run;
    logic [W_BYTE-1:0] o_out_byte;
    logic              o_out_valid;
    logic              o_last;
    logic [W_LVL-1:0]  o_used_bytes;
    logic [W_LVL-1:0]  o_free_bytes;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [W_LVL-1:0]  i_cfg_data;

    int   errors;
    int   pending;
    int   checked;
    int   send_idle;      // percent of cycles the sender skips
    int   recv_idle;      // percent of cycles the receiver skips
    int   words_sent;
    int   cfg_writes;
    int   stall_cycles;
    logic hold_req;       // asks the receiver for one long stall

    // 2 ns clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    byte_ring_fifo uut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .push              (push),
        .full              (full),
        .i_operation       (i_operation),
        .i_push_byte       (i_push_byte),
        .i_push_last       (i_push_last),
        .i_pop_count       (i_pop_count),
        .empty             (empty),
        .pop               (pop),
        .o_accepted        (o_accepted),
        .o_accepted_in_run (o_accepted_in_run),
        .o_out_byte        (o_out_byte),
        .o_out_valid       (o_out_valid),
        .o_last            (o_last),
        .o_used_bytes      (o_used_bytes),
        .o_free_bytes      (o_free_bytes),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    byte_ring_fifo_checker ring_check (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_push            (push),
        .i_full            (full),
        .i_operation       (i_operation),
        .i_push_byte       (i_push_byte),
        .i_push_last       (i_push_last),
        .i_pop_count       (i_pop_count),
        .i_empty           (empty),
        .i_pop             (pop),
        .i_accepted        (o_accepted),
        .i_accepted_in_run (o_accepted_in_run),
        .i_out_byte        (o_out_byte),
        .i_out_valid       (o_out_valid),
        .i_last            (o_last),
        .i_used_bytes      (o_used_bytes),
        .i_free_bytes      (o_free_bytes),
        .i_cfg_valid       (i_cfg_valid),
        .i_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data),
        .o_errors          (errors),
        .o_pending         (pending),
        .o_checked         (checked)
    );

    // offer one word, with a random gap first; push is left high on return
    // so that back to back words never drop it in between
    task automatic send_word(input logic op, input logic [W_BYTE-1:0] data,
                             input logic lst, input logic [W_CNT-1:0] cnt);
        while ($urandom_range(0, 99) < send_idle) begin
            push <= 1'b0;
            @(negedge i_clk);
        end
        push        <= 1'b1;
        i_operation <= op;
        i_push_byte <= data;
        i_push_last <= lst;
        i_pop_count <= cnt;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        words_sent++;
        @(negedge i_clk);
    endtask

    // stop offering and wait for every predicted result word to come out
    task automatic drain();
        push <= 1'b0;
        while (pending != 0) @(negedge i_clk);
    endtask

    // capacity write, only ever issued with the fifo drained
    task automatic write_capacity(input logic [W_LVL-1:0] value);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // receiver: random pop, or one long stall when asked
    initial begin
        pop = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                pop <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else begin
                pop <= ($urandom_range(0, 99) >= recv_idle);
            end
        end
    end

    // watchdog on cycles with no handshake on any channel
    always @(posedge i_clk) begin
        if ((push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= WATCHDOG_LIMIT) begin
                $display("watchdog: no handshake for %0d cycles, %0d words left",
                         WATCHDOG_LIMIT, pending);
                $display("byte_ring_fifo test failed");
                $finish;
            end
        end
    end

    initial begin
        int ph;
        int k;
        int r;
        int cnt;
        i_rst_n      = 1'b0;
        push         = 1'b0;
        i_operation  = OP_PUSH;
        i_push_byte  = '0;
        i_push_last  = 1'b0;
        i_pop_count  = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_data   = '0;
        hold_req     = 1'b0;
        send_idle    = 11;
        recv_idle    = 54;
        words_sent   = 0;
        cfg_writes   = 0;
        stall_cycles = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed, capacity still at its reset value of 1024
        send_word(OP_POP,  8'h00, 1'b0, 7'd5);     // pop on an empty ring
        send_word(OP_PUSH, 8'h00, 1'b0, 7'd0);
        send_word(OP_PUSH, 8'hFF, 1'b0, 7'd127);
        send_word(OP_PUSH, 8'hA5, 1'b1, 7'd0);     // ends the run of three
        send_word(OP_PUSH, 8'h5A, 1'b0, 7'd0);     // run count starts over
        send_word(OP_POP,  8'hFF, 1'b1, 7'd0);     // zero count with data held
        send_word(OP_POP,  8'h00, 1'b0, 7'd127);   // count above the pop limit
        send_word(OP_POP,  8'h00, 1'b0, 7'd64);
        drain();

        // one byte ring: second push finds it full, a dropped last still ends the run
        write_capacity(11'd1);
        send_word(OP_PUSH, 8'h3C, 1'b0, 7'd0);
        send_word(OP_PUSH, 8'hC3, 1'b1, 7'd0);
        send_word(OP_PUSH, 8'h81, 1'b0, 7'd0);
        send_word(OP_POP,  8'h00, 1'b0, 7'd1);
        drain();

        // zero capacity behaves as one
        write_capacity(11'd0);
        send_word(OP_PUSH, 8'h7E, 1'b1, 7'd0);
        send_word(OP_POP,  8'h00, 1'b0, 7'd2);
        drain();

        // all ones clamps to the store depth
        write_capacity(11'd2047);
        send_word(OP_PUSH, 8'h11, 1'b0, 7'd0);
        send_word(OP_POP,  8'h00, 1'b0, 7'd1);
        drain();

        // small ring while the receiver stalls: results back up, the input
        // goes full, the ring fills and the later pushes are dropped
        write_capacity(11'd8);
        send_idle = 0;
        recv_idle = 0;
        @(posedge i_clk);
        hold_req = 1'b1;
        @(negedge i_clk);
        for (k = 0; k < 12; k++)
            send_word(OP_PUSH, W_BYTE'($urandom_range(0, 255)), k == 11, 7'd0);
        send_word(OP_POP,  8'h00, 1'b0, 7'd127);   // clamped, returns all eight
        send_word(OP_POP,  8'h00, 1'b0, 7'd3);     // ring already empty
        drain();

        // random phases: slow receiver, slow sender, then no idling
        for (ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin
                    send_idle = 11;
                    recv_idle = 54;
                    write_capacity(11'd3);
                end
                1: begin
                    send_idle = 54;
                    recv_idle = 11;
                    write_capacity(11'd1025);
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                    write_capacity(W_LVL'($urandom_range(1, 40)));
                end
            endcase
            for (k = 0; k < RANDOM_WORDS; k++) begin
                // mostly short pops, some long ones, a few above the pop limit
                r   = $urandom_range(0, 9);
                cnt = (r < 7) ? $urandom_range(0, 6) :
                      (r < 9) ? $urandom_range(7, 64) : $urandom_range(65, 127);
                send_word(($urandom_range(0, 9) < 6) ? OP_PUSH : OP_POP,
                          W_BYTE'($urandom_range(0, 255)),
                          $urandom_range(0, 3) == 0, W_CNT'(cnt));
            end
            drain();
        end

        // nothing more may come out after the last expected word
        repeat (END_SETTLE) @(negedge i_clk);

        $display("covered %0d input words and %0d result words over %0d capacity writes,",
                 words_sent, checked, cfg_writes);
        $display("including a filled ring with dropped pushes, clamped capacities and a long stall");
        if (errors == 0 && pending == 0) begin
            $display("byte_ring_fifo test passed");
        end else begin
            $display("%0d mismatches, %0d result words never seen", errors, pending);
            $display("byte_ring_fifo test failed");
        end
        $finish;
    end

endmodule
